FILE: sv/wlm_pkg.sv
// Shared types and constants of the waypoint linear mover.
// Used by wlm_queue, wlm_engine and waypoint_linear_mover; no dependencies.
package wlm_pkg;

    localparam int IN_CW    = 32;   // coordinate width on the ports
    localparam int SPEED_W  = 31;   // move_speed register width
    localparam int PROG_W   = 17;   // Q1.16 progress and step
    localparam int QUOT_W   = 16;   // quotient bits of the step division
    localparam int LEFT_W   = 5;    // waypoints_left width

    localparam logic [PROG_W-1:0]  ONE_Q16     = 17'h10000;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 31'd65536;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_PUSH = 2'd1;
    localparam logic [1:0] ACT_SET  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ODIFF,
        ST_OABS,
        ST_OSQR,
        ST_ROOT,
        ST_CMP,
        ST_DIV,
        ST_PROG,
        ST_LDIFF,
        ST_LABS,
        ST_LMUL,
        ST_LADD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [LEFT_W-1:0] left;
    } q_stat_t;

    typedef struct packed {
        logic              push_dropped;
        logic [LEFT_W-1:0] waypoints_left;
        logic              arrived;
        logic [IN_CW-1:0]  pos_z;
        logic [IN_CW-1:0]  pos_y;
        logic [IN_CW-1:0]  pos_x;
    } result_t;

endpackage

FILE: sv/waypoint_linear_mover.sv
// Top level of the waypoint linear mover: stream ports, speed register, result register.
// Depends on wlm_pkg, wlm_queue and wlm_engine.
//
// Each input beat pushes a waypoint, sets the position or ticks the mover, and gives
// exactly one result beat; items run one at a time. Push, set, unused actions and ticks
// with an empty queue go from decode straight to the result. A tick of an open segment
// runs the progress update and three shift-add multiplies on the one shared adder for
// the interpolation. The first tick of a segment adds the distance work on the same
// adder: three shift-add squares, a square root and a compare, plus a division when
// the distance exceeds move_speed.
// The input is not ready while an item is in work. A finished result moves to the output
// register, and the next result waits in the engine while that register is still full.
module waypoint_linear_mover #(
    parameter int WAYPOINT_DEPTH = 16,
    parameter int COORD_WIDTH    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // coord_x, coord_y, coord_z
    input  logic [1:0]    s_tuser,   // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // pos_x, pos_y, pos_z, arrived, waypoints_left,
                                     // push_dropped, zero pad
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [30:0]   cfg_data   // move_speed
);
    import wlm_pkg::*;

    logic [SPEED_W-1:0]       speed_reg;
    logic                     m_tvalid_reg;
    result_t                  m_data_reg;
    result_t                  res;
    logic                     res_valid, res_free;
    q_ctrl_t                  q_ctrl;
    q_stat_t                  q_stat;
    logic [3*COORD_WIDTH-1:0] q_rd, q_wr;

    wlm_queue #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .wr_data (q_wr),
        .rd_data (q_rd),
        .stat    (q_stat)
    );

    wlm_engine #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .speed     (speed_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_x      (s_tdata[31:0]),
        .in_y      (s_tdata[63:32]),
        .in_z      (s_tdata[95:64]),
        .target    (q_rd),
        .wr_data   (q_wr),
        .q_stat    (q_stat),
        .q_ctrl    (q_ctrl),
        .res       (res),
        .res_valid (res_valid),
        .res_free  (res_free)
    );

    assign cfg_ready = 1'b1;
    assign res_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= SPEED_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                speed_reg <= cfg_data;
            end
            if (res_free)
            begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

FILE: sv/wlm_queue.sv
// Circular waypoint queue: memory of x,y,z entries with head and fill count.
// Depends on wlm_pkg.
module wlm_queue #(
    parameter int WAYPOINT_DEPTH = 16,
    parameter int COORD_WIDTH    = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wlm_pkg::q_ctrl_t         ctrl,
    input  logic [3*COORD_WIDTH-1:0] wr_data,
    output logic [3*COORD_WIDTH-1:0] rd_data,
    output wlm_pkg::q_stat_t         stat
);
    import wlm_pkg::*;

    localparam int IW  = $clog2(WAYPOINT_DEPTH);
    localparam int CTW = $clog2(WAYPOINT_DEPTH + 1);
    localparam int SMW = IW + 2;

    logic [3*COORD_WIDTH-1:0] mem [WAYPOINT_DEPTH];
    logic [3*COORD_WIDTH-1:0] rd_reg;
    logic [IW-1:0]            head_reg, head_next;
    logic [CTW-1:0]           count_reg, count_next;
    logic [SMW-1:0]           tail_sum;
    logic [IW-1:0]            tail;

    always_comb
    begin
        tail_sum = SMW'(head_reg) + SMW'(count_reg);
        if (tail_sum >= SMW'(WAYPOINT_DEPTH))
        begin
            tail = IW'(tail_sum - SMW'(WAYPOINT_DEPTH));
        end
        else
        begin
            tail = IW'(tail_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= wr_data;
        end
        rd_reg <= mem[head_reg];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == IW'(WAYPOINT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign rd_data    = rd_reg;
    assign stat.full  = (count_reg == CTW'(WAYPOINT_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.left  = LEFT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CTW'(WAYPOINT_DEPTH))
        else $error("queue count exceeds depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (count_reg != '0))
        else $error("pop from empty queue");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && !ctrl.pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not raise the count");

endmodule

FILE: sv/wlm_engine.sv
// Sequencer and shared add/subtract unit: segment distance by shift-add squares,
// digit-by-digit square root, restoring division and shift-add interpolation.
// Depends on wlm_pkg.
module wlm_engine #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [wlm_pkg::SPEED_W-1:0]    speed,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_action,
    input  logic signed [wlm_pkg::IN_CW-1:0] in_x,
    input  logic signed [wlm_pkg::IN_CW-1:0] in_y,
    input  logic signed [wlm_pkg::IN_CW-1:0] in_z,
    input  logic [3*COORD_WIDTH-1:0]       target,
    output logic [3*COORD_WIDTH-1:0]       wr_data,
    input  wlm_pkg::q_stat_t               q_stat,
    output wlm_pkg::q_ctrl_t               q_ctrl,
    output wlm_pkg::result_t               res,
    output logic                           res_valid,
    input  logic                           res_free
);
    import wlm_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = CW + 1;       // magnitude of a coordinate difference
    localparam int NR   = CW + 2;       // root bits
    localparam int SW   = 2 * NR;       // sum of squares
    localparam int AW   = SW + 1;       // shared adder
    localparam int RMW  = NR + 2;       // root and division remainder
    localparam int CNTW = $clog2(NR + 1);

    state_t                  state_reg, state_next;
    logic [1:0]              act_reg, act_next;
    logic signed [CW-1:0]    inp_reg [3];
    logic signed [CW-1:0]    inp_next [3];
    logic signed [CW-1:0]    pos_reg [3];
    logic signed [CW-1:0]    pos_next [3];
    logic signed [CW-1:0]    start_reg [3];
    logic signed [CW-1:0]    start_next [3];
    logic [SW-1:0]           acc_reg, acc_next;
    logic [SW-1:0]           mcand_reg, mcand_next;
    logic [MW-1:0]           mplier_reg, mplier_next;
    logic signed [CW:0]      m_reg, m_next;
    logic                    neg_reg, neg_next;
    logic [RMW-1:0]          rem_reg, rem_next;
    logic [NR-1:0]           root_reg, root_next;
    logic [QUOT_W-1:0]       q_reg, q_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [1:0]              axis_reg, axis_next;
    logic [PROG_W-1:0]       progress_reg, progress_next;
    logic [PROG_W-1:0]       step_reg, step_next;
    logic                    open_reg, open_next;
    logic                    arrived_reg, arrived_next;
    logic                    dropped_reg, dropped_next;

    logic [AW-1:0]           alu_a, alu_b, alu_res;
    logic                    alu_sub, alu_neg;
    logic signed [CW-1:0]    tgt;
    logic signed [CW-1:0]    start_sel;
    logic [RMW+1:0]          rem_cat;
    logic [RMW:0]            div_r2;
    logic [PROG_W:0]         prog_sum;

    always_comb
    begin
        case (axis_reg)
            2'd0:    tgt = target[CW-1:0];
            2'd1:    tgt = target[2*CW-1:CW];
            default: tgt = target[3*CW-1:2*CW];
        endcase
    end

    assign start_sel = start_reg[axis_reg];
    assign rem_cat   = {rem_reg, acc_reg[SW-1:SW-2]};
    assign div_r2    = {rem_reg, 1'b0};

    // Shared adder: every arithmetic step of the sequencer goes through here.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_ODIFF, ST_LDIFF:
            begin
                alu_a   = AW'(tgt);
                alu_b   = AW'(start_sel);
                alu_sub = 1'b1;
            end
            ST_OABS, ST_LABS:
            begin
                if (m_reg[CW])
                begin
                    alu_b   = AW'(m_reg);
                    alu_sub = 1'b1;
                end
                else
                begin
                    alu_a = AW'(m_reg);
                end
            end
            ST_OSQR, ST_LMUL:
            begin
                alu_a = AW'(acc_reg);
                alu_b = AW'(mcand_reg);
            end
            ST_ROOT:
            begin
                alu_a   = AW'(rem_cat);
                alu_b   = AW'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            ST_CMP:
            begin
                alu_a   = AW'(speed);
                alu_b   = AW'(root_reg);
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = AW'(div_r2);
                alu_b   = AW'(root_reg);
                alu_sub = 1'b1;
            end
            ST_PROG:
            begin
                alu_a = AW'(progress_reg);
                alu_b = AW'(step_reg);
            end
            ST_LADD:
            begin
                alu_a   = AW'(start_sel);
                alu_b   = AW'(acc_reg[SW-1:16]);
                alu_sub = neg_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
        alu_neg  = alu_res[AW-1];
        prog_sum = alu_res[PROG_W:0];
    end

    always_comb
    begin
        logic [QUOT_W-1:0] q_nx;
        state_next    = state_reg;
        act_next      = act_reg;
        inp_next      = inp_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        m_next        = m_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        axis_next     = axis_reg;
        progress_next = progress_reg;
        step_next     = step_reg;
        open_next     = open_reg;
        arrived_next  = arrived_reg;
        dropped_next  = dropped_reg;
        q_ctrl        = '0;
        res_valid     = 1'b0;
        q_nx          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_action;
                    inp_next[0]  = CW'(in_x);
                    inp_next[1]  = CW'(in_y);
                    inp_next[2]  = CW'(in_z);
                    arrived_next = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FIN;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (q_stat.full)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            q_ctrl.push = 1'b1;
                        end
                    end
                    ACT_SET:
                    begin
                        pos_next = inp_reg;
                    end
                    ACT_TICK:
                    begin
                        if (!q_stat.empty)
                        begin
                            axis_next = 2'd0;
                            if (!open_reg)
                            begin
                                start_next = pos_reg;
                                acc_next   = '0;
                                state_next = ST_ODIFF;
                            end
                            else
                            begin
                                state_next = ST_PROG;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_ODIFF:
            begin
                m_next     = alu_res[MW-1:0];
                state_next = ST_OABS;
            end
            ST_OABS:
            begin
                mcand_next  = SW'(alu_res[MW-1:0]);
                mplier_next = alu_res[MW-1:0];
                cnt_next    = '0;
                state_next  = ST_OSQR;
            end
            ST_OSQR:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res[SW-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(MW - 1))
                begin
                    if (axis_reg == 2'd2)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_ODIFF;
                    end
                end
            end
            ST_ROOT:
            begin
                // One root bit per cycle; the radicand shifts out two bits at a time.
                acc_next = acc_reg << 2;
                if (!alu_neg)
                begin
                    rem_next  = alu_res[RMW-1:0];
                    root_next = {root_reg[NR-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_cat[RMW-1:0];
                    root_next = {root_reg[NR-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NR - 1))
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                progress_next = '0;
                open_next     = 1'b1;
                if (alu_neg)
                begin
                    // The distance exceeds the speed, so speed fits the remainder.
                    rem_next   = RMW'(speed);
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next  = ONE_Q16;
                    state_next = ST_PROG;
                end
            end
            ST_DIV:
            begin
                if (!alu_neg)
                begin
                    rem_next = alu_res[RMW-1:0];
                    q_nx     = {q_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_r2[RMW-1:0];
                    q_nx     = {q_reg[QUOT_W-2:0], 1'b0};
                end
                q_next   = q_nx;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QUOT_W - 1))
                begin
                    step_next  = (q_nx == '0) ? PROG_W'(1) : PROG_W'(q_nx);
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                progress_next = (prog_sum > (PROG_W + 1)'(ONE_Q16)) ? ONE_Q16
                                                                    : prog_sum[PROG_W-1:0];
                axis_next     = 2'd0;
                state_next    = ST_LDIFF;
            end
            ST_LDIFF:
            begin
                m_next     = alu_res[MW-1:0];
                state_next = ST_LABS;
            end
            ST_LABS:
            begin
                mcand_next  = SW'(alu_res[MW-1:0]);
                mplier_next = MW'(progress_reg);
                neg_next    = m_reg[CW];
                acc_next    = '0;
                cnt_next    = '0;
                state_next  = ST_LMUL;
            end
            ST_LMUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res[SW-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(PROG_W - 1))
                begin
                    state_next = ST_LADD;
                end
            end
            ST_LADD:
            begin
                pos_next[axis_reg] = alu_res[CW-1:0];
                if (axis_reg == 2'd2)
                begin
                    if (progress_reg == ONE_Q16)
                    begin
                        q_ctrl.pop   = 1'b1;
                        arrived_next = 1'b1;
                        open_next    = 1'b0;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_LDIFF;
                end
            end
            ST_FIN:
            begin
                res_valid = 1'b1;
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '{default: '0};
            start_reg    <= '{default: '0};
            progress_reg <= '0;
            step_reg     <= '0;
            open_reg     <= 1'b0;
            arrived_reg  <= 1'b0;
            dropped_reg  <= 1'b0;
            axis_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            progress_reg <= progress_next;
            step_reg     <= step_next;
            open_reg     <= open_next;
            arrived_reg  <= arrived_next;
            dropped_reg  <= dropped_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        inp_reg    <= inp_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        m_reg      <= m_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        q_reg      <= q_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign wr_data  = {inp_reg[2], inp_reg[1], inp_reg[0]};

    assign res.pos_x          = IN_CW'(pos_reg[0]);
    assign res.pos_y          = IN_CW'(pos_reg[1]);
    assign res.pos_z          = IN_CW'(pos_reg[2]);
    assign res.arrived        = arrived_reg;
    assign res.waypoints_left = q_stat.left;
    assign res.push_dropped   = dropped_reg;

    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg <= ONE_Q16)
        else $error("progress above one");
    a_lerp_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LMUL || state_reg == ST_LADD) |-> open_reg)
        else $error("interpolating without an open segment");
    a_arrive_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && arrived_reg) |-> (!open_reg && progress_reg == ONE_Q16))
        else $error("arrival without full progress");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for waypoint_linear_mover: directed table, then random traffic
// checked beat by beat against a behavioral predictor of the mover.
// Depends on wlm_pkg and the waypoint_linear_mover RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wlm_pkg::*;

    localparam int DEPTH     = 16;
    localparam int IDLE_TAIL = 300;
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_LEN  = 700;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] cx, cy, cz;
        bit          typed;
        result_t     res;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = ACT_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [30:0]  cfg_data = '0;

    // Mover model state.
    longint      wp_store [DEPTH][3];
    longint      cur_pos [3];
    longint      seg_from [3];
    int          wp_head, wp_count;
    int unsigned prog_q16, step_q16;
    bit          seg_open;
    int unsigned speed_q16;

    result_t expected_pos_q[$];
    int      fail_count = 0;
    bit      hold_req = 1'b0;
    int      burst_left = 0;
    row_t    rows[$];

    waypoint_linear_mover DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint signed_coord(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] sq);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cw;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            cw = c;
            if (cw * cw <= sq)
                r = c;
        end
        return r;
    endfunction

    function automatic longint lerp_coord(longint a, longint b, int unsigned p);
        longint d;
        longint m;
        longint off;
        d = b - a;
        m = d < 0 ? -d : d;
        off = (m >>> 16) * longint'(p) + (((m & 64'hFFFF) * longint'(p)) >>> 16);
        return d < 0 ? a - off : a + off;
    endfunction

    function automatic void start_segment();
        logic [127:0] sq;
        logic [127:0] mw;
        logic [63:0]  seg_len;
        logic [63:0]  q;
        longint       d;
        sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            seg_from[k] = cur_pos[k];
            d = wp_store[wp_head][k] - cur_pos[k];
            mw = d < 0 ? -d : d;
            sq += mw * mw;
        end
        seg_len = root_floor(sq);
        if (seg_len <= speed_q16)
            step_q16 = 32'h10000;
        else
        begin
            q = (64'(speed_q16) << 16) / seg_len;
            step_q16 = q == 0 ? 1 : int'(q);
        end
        prog_q16 = 0;
        seg_open = 1'b1;
    endfunction

    function automatic result_t move_once(logic [1:0] act, logic [31:0] cx, cy, cz);
        result_t r;
        longint  pt [3];
        pt[0] = signed_coord(cx);
        pt[1] = signed_coord(cy);
        pt[2] = signed_coord(cz);
        r = '0;
        if (act == ACT_PUSH)
        begin
            if (wp_count >= DEPTH)
                r.push_dropped = 1'b1;
            else
            begin
                wp_store[(wp_head + wp_count) % DEPTH] = pt;
                wp_count++;
            end
        end
        else if (act == ACT_SET)
            cur_pos = pt;
        else if (act == ACT_TICK && wp_count > 0)
        begin
            if (!seg_open)
                start_segment();
            prog_q16 += step_q16;
            if (prog_q16 > 32'h10000)
                prog_q16 = 32'h10000;
            for (int k = 0; k < 3; k++)
                cur_pos[k] = lerp_coord(seg_from[k], wp_store[wp_head][k], prog_q16);
            if (prog_q16 >= 32'h10000)
            begin
                wp_head = (wp_head + 1) % DEPTH;
                wp_count--;
                seg_open = 1'b0;
                r.arrived = 1'b1;
            end
        end
        r.pos_x = cur_pos[0][31:0];
        r.pos_y = cur_pos[1][31:0];
        r.pos_z = cur_pos[2][31:0];
        r.waypoints_left = wp_count[4:0];
        return r;
    endfunction

    // Sender: bursts of beats separated by random gaps; valid stays high inside a burst.
    task automatic send_item(logic [1:0] act, logic [31:0] cx, cy, cz, bit typed, result_t tr);
        result_t pr;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {cz, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pr = move_once(act, cx, cy, cz);
        expected_pos_q.push_back(typed ? tr : pr);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pos_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_TAIL) @(negedge clk);
    endtask

    task automatic write_speed(logic [30:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        speed_q16 = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 1) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
    endfunction

    function automatic void add_row(logic [1:0] act, logic [31:0] cx, cy, cz, bit typed,
                                    logic [31:0] ex, ey, ez, logic arr, logic [4:0] left,
                                    logic drop);
        row_t w;
        w.act = act; w.cx = cx; w.cy = cy; w.cz = cz; w.typed = typed;
        w.res = '{push_dropped: drop, waypoints_left: left, arrived: arr,
                  pos_z: ez, pos_y: ey, pos_x: ex};
        rows.push_back(w);
    endfunction

    // Receiver: ready pattern switches every so often; a held-off stretch on request.
    always @(negedge clk)
    begin : receiver
        static int mode = 0;
        static int cnt = 0;
        if (hold_req)
        begin
            m_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clk);
            hold_req = 1'b0;
        end
        if (cnt == 0)
        begin
            mode = $urandom_range(0, 3);
            cnt = $urandom_range(20, 200);
        end
        cnt--;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= cnt[2];
        endcase
    end

    always @(posedge clk)
    begin : checker_blk
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[102:0];
            if (expected_pos_q.size() == 0)
            begin
                $error("unexpected result beat %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_pos_q.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x exp %h got %h", want.pos_x, got.pos_x); fail_count++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y exp %h got %h", want.pos_y, got.pos_y); fail_count++;
                end
                if (got.pos_z !== want.pos_z)
                begin
                    $error("pos_z exp %h got %h", want.pos_z, got.pos_z); fail_count++;
                end
                if (got.arrived !== want.arrived)
                begin
                    $error("arrived exp %b got %b", want.arrived, got.arrived); fail_count++;
                end
                if (got.waypoints_left !== want.waypoints_left)
                begin
                    $error("waypoints_left exp %0d got %0d", want.waypoints_left,
                           got.waypoints_left);
                    fail_count++;
                end
                if (got.push_dropped !== want.push_dropped)
                begin
                    $error("push_dropped exp %b got %b", want.push_dropped, got.push_dropped);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        static int idle_cycles = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [30:0] speeds [6];
        logic [1:0]  act;
        int          pick;
        speeds = '{31'h7FFFFFFF, 31'd1, 31'h10000, 31'h0, 31'h0004_0000, 31'h2AAA_5555};
        speeds[3] = $urandom_range(2, 32'h7FFFFFFE);
        wp_head = 0; wp_count = 0; prog_q16 = 0; step_q16 = 0; seg_open = 1'b0;
        speed_q16 = SPEED_RESET;
        for (int k = 0; k < 3; k++)
        begin
            cur_pos[k] = 0;
            seg_from[k] = 0;
        end

        // Directed part at the reset speed of 1.0 per tick.
        add_row(ACT_TICK, '1, '1, '1, 1, 0, 0, 0, 0, 0, 0);           // empty queue
        add_row(ACT_NONE, '1, '1, '1, 1, 0, 0, 0, 0, 0, 0);           // unused action
        add_row(ACT_SET, 32'h7FFFFFFF, 32'h80000000, 0, 1,
                32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0);
        add_row(ACT_SET, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ACT_PUSH, 32'h20000, 0, 0, 1, 0, 0, 0, 0, 1, 0);
        add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_SET, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0);               // set mid-segment
        add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_PUSH, 32'h20000, 0, 0, 0, 0, 0, 0, 0, 0, 0);      // zero distance
        add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_SET, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_PUSH, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 15; i++)
            add_row(ACT_PUSH, $urandom(), $urandom(), $urandom(), 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_PUSH, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0);               // full queue push

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_item(rows[i].act, rows[i].cx, rows[i].cy, rows[i].cz, rows[i].typed,
                      rows[i].res);
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_speed(speeds[ph]);
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < 170; n++)
            begin
                pick = $urandom_range(0, 99);
                act = pick < 30 ? ACT_PUSH : pick < 88 ? ACT_TICK :
                      pick < 96 ? ACT_SET : ACT_NONE;
                send_item(act, rand_coord(), rand_coord(), rand_coord(), 0, '0);
            end
            drain_results();
        end
        write_speed(SPEED_RESET);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
